### design/kplock_pkg.sv
// ----------------------------------------------------------------------------
// kplock_pkg
// shared types and constants of the keypad login and password lock
// ----------------------------------------------------------------------------
package kplock_pkg;

	localparam int KeyW        = 4;
	localparam int KeysPerCode = 3;
	localparam int CodeW       = KeyW * KeysPerCode;
	localparam int NumUsers    = 3;
	localparam int UserW       = 2;
	localparam int CountW      = 2;
	localparam int CfgIdxW     = 3;

	// result codes
	typedef enum logic [2:0] {
		ST_KEY       = 3'd0,
		ST_LOGIN_BAD = 3'd1,
		ST_LOGIN_OK  = 3'd2,
		ST_GRANTED   = 3'd3,
		ST_PASS_BAD  = 3'd4,
		ST_FIRE      = 3'd5
	} status_t;

	// event kinds
	typedef enum logic {
		OP_KEY  = 1'b0,
		OP_FIRE = 1'b1
	} op_t;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_U1_LOGIN  = 3'd0,
		REG_U1_SECRET = 3'd1,
		REG_U2_LOGIN  = 3'd2,
		REG_U2_SECRET = 3'd3,
		REG_U3_LOGIN  = 3'd4,
		REG_U3_SECRET = 3'd5
	} reg_idx_t;

	// entry phase, one-hot
	typedef enum logic [1:0] {
		PH_LOGIN = 2'b01,
		PH_PASS  = 2'b10
	} phase_t;

	typedef logic [KeyW-1:0]  key_t;
	typedef logic [CodeW-1:0] code_t;
	typedef logic [UserW-1:0] user_id_t;

	typedef struct packed {
		op_t  operation;
		key_t key_index;
	} req_t;

	typedef struct packed {
		status_t  status;
		user_id_t user_id;
		key_t     key_echo;
		logic     door_unlock;
		logic     alarm;
	} rsp_t;

	typedef struct packed {
		code_t login;
		code_t secret;
	} user_cred_t;

	typedef user_cred_t [NumUsers-1:0] creds_t;

	// register values after reset
	localparam code_t U1LoginRst  = 12'd891;
	localparam code_t U1SecretRst = 12'd18;
	localparam code_t U2LoginRst  = 12'd1983;
	localparam code_t U2SecretRst = 12'd292;
	localparam code_t U3LoginRst  = 12'd3068;
	localparam code_t U3SecretRst = 12'd581;

endpackage

### design/kplock_ifs.sv
// ----------------------------------------------------------------------------
// kplock interfaces
// valid/ready request channel and configuration write channel
// ----------------------------------------------------------------------------
interface kplock_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface kplock_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [kplock_pkg::CfgIdxW-1:0]   reg_index;
	kplock_pkg::code_t                wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

### design/kplock_core.sv
// ----------------------------------------------------------------------------
// kplock_core
// entry state and the per-request step: key collection, login and
// password compares, result build
// ----------------------------------------------------------------------------
module kplock_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  kplock_pkg::req_t   req,
	input  kplock_pkg::creds_t creds,
	output kplock_pkg::rsp_t   rsp
);

	kplock_pkg::phase_t            phase_q,   phase_d;
	logic [kplock_pkg::CountW-1:0] entry_count_q, entry_count_d;
	kplock_pkg::code_t             entered_q, entered_d;
	kplock_pkg::user_id_t          matched_q, matched_d;

	kplock_pkg::code_t             keys_nx;
	logic [kplock_pkg::CountW-1:0] count_nx;
	kplock_pkg::user_id_t          login_user;
	logic                          secret_ok;

	// parallel compares against all users, last match wins
	always_comb begin
		keys_nx    = {entered_q[kplock_pkg::CodeW-kplock_pkg::KeyW-1:0], req.key_index};
		count_nx   = entry_count_q + kplock_pkg::CountW'(1);
		login_user = '0;
		secret_ok  = 1'b0;
		for (int i = 0; i < kplock_pkg::NumUsers; i++) begin
			if (keys_nx == creds[i].login) begin
				login_user = kplock_pkg::UserW'(i + 1);
			end
			if (matched_q == kplock_pkg::UserW'(i + 1) && keys_nx == creds[i].secret) begin
				secret_ok = 1'b1;
			end
		end
	end

	always_comb begin
		phase_d       = phase_q;
		entry_count_d = entry_count_q;
		entered_d     = entered_q;
		matched_d     = matched_q;
		rsp.status      = kplock_pkg::ST_KEY;
		rsp.user_id     = '0;
		rsp.key_echo    = req.key_index;
		rsp.door_unlock = 1'b0;
		rsp.alarm       = 1'b0;
		if (req.operation == kplock_pkg::OP_FIRE) begin
			// entry state untouched
			rsp.status      = kplock_pkg::ST_FIRE;
			rsp.key_echo    = '0;
			rsp.door_unlock = 1'b1;
			rsp.alarm       = 1'b1;
		end else if (count_nx != kplock_pkg::CountW'(kplock_pkg::KeysPerCode)) begin
			entered_d     = keys_nx;
			entry_count_d = count_nx;
			rsp.user_id   = (phase_q == kplock_pkg::PH_PASS) ? matched_q : '0;
		end else begin
			entered_d     = '0;
			entry_count_d = '0;
			case (phase_q)
				kplock_pkg::PH_LOGIN: begin
					if (login_user == '0) begin
						rsp.status = kplock_pkg::ST_LOGIN_BAD;
					end else begin
						rsp.status  = kplock_pkg::ST_LOGIN_OK;
						rsp.user_id = login_user;
						matched_d   = login_user;
						phase_d     = kplock_pkg::PH_PASS;
					end
				end
				kplock_pkg::PH_PASS: begin
					rsp.user_id = matched_q;
					if (secret_ok) begin
						rsp.status      = kplock_pkg::ST_GRANTED;
						rsp.door_unlock = 1'b1;
					end else begin
						rsp.status = kplock_pkg::ST_PASS_BAD;
					end
					matched_d = '0;
					phase_d   = kplock_pkg::PH_LOGIN;
				end
				default: begin
					matched_d = '0;
					phase_d   = kplock_pkg::PH_LOGIN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= kplock_pkg::PH_LOGIN;
			entry_count_q <= '0;
			entered_q     <= '0;
			matched_q     <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			entry_count_q <= entry_count_d;
			entered_q     <= entered_d;
			matched_q     <= matched_d;
		end
	end

	a_login_no_user: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == kplock_pkg::PH_LOGIN |-> matched_q == '0)
		else $error("user held during login phase");

	a_pass_has_user: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == kplock_pkg::PH_PASS |-> matched_q != '0)
		else $error("password phase without a user");

	a_count_short: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q != kplock_pkg::CountW'(kplock_pkg::KeysPerCode))
		else $error("full code left in the entry buffer");

	a_fire_keeps_entry: assert property (@(posedge clk) disable iff (!arst_n)
		step && req.operation == kplock_pkg::OP_FIRE |=>
		$stable(phase_q) && $stable(entry_count_q) && $stable(entered_q) && $stable(matched_q))
		else $error("fire event changed the entry state");

	a_unlock_cause: assert property (@(posedge clk) disable iff (!arst_n)
		step && rsp.door_unlock |->
		rsp.status == kplock_pkg::ST_GRANTED || rsp.status == kplock_pkg::ST_FIRE)
		else $error("door released without grant or fire");

endmodule

### design/keypad_login_password_lock.sv
// ----------------------------------------------------------------------------
// keypad_login_password_lock
// an accepted request waits in the input register until the result register is
// free or being emptied, then moves into it
// throughput: one request per cycle while results are taken, set by the input
// and result registers; the single-pass compare step never stalls on its own
// reset: arst_n clears the channels and the entry state, users get default codes
// ----------------------------------------------------------------------------
module keypad_login_password_lock (
	input  logic              clk,
	input  logic              arst_n,
	kplock_stream_if.sink     keys,
	kplock_stream_if.source   result,
	kplock_cfg_if.sink        cfg
);

	// input register stage
	logic              in_valid_s1;
	kplock_pkg::req_t  in_req_s1;

	// result register stage
	logic              out_valid_s2;
	kplock_pkg::rsp_t  out_rsp_s2;

	// user login and secret registers
	kplock_pkg::creds_t creds_q;

	kplock_pkg::rsp_t  step_rsp;
	logic              advance;

	// the held request moves on when the result register is free or being emptied
	assign advance    = in_valid_s1 && (!out_valid_s2 || result.ready);

	// take a new request when the input register is empty or empties in the same cycle
	assign keys.ready = !in_valid_s1 || advance;

	assign result.valid = out_valid_s2;
	assign result.data  = out_rsp_s2;

	// writes land straight in the registers, so the port never stalls
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (keys.valid && keys.ready) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (keys.valid && keys.ready) begin
			in_req_s1 <= keys.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (result.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_rsp_s2 <= step_rsp;
		end
	end

	// configuration registers, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			creds_q[0].login  <= kplock_pkg::U1LoginRst;
			creds_q[0].secret <= kplock_pkg::U1SecretRst;
			creds_q[1].login  <= kplock_pkg::U2LoginRst;
			creds_q[1].secret <= kplock_pkg::U2SecretRst;
			creds_q[2].login  <= kplock_pkg::U3LoginRst;
			creds_q[2].secret <= kplock_pkg::U3SecretRst;
		end else if (cfg.valid && cfg.ready) begin
			case (kplock_pkg::reg_idx_t'(cfg.reg_index))
				kplock_pkg::REG_U1_LOGIN:  creds_q[0].login  <= cfg.wdata;
				kplock_pkg::REG_U1_SECRET: creds_q[0].secret <= cfg.wdata;
				kplock_pkg::REG_U2_LOGIN:  creds_q[1].login  <= cfg.wdata;
				kplock_pkg::REG_U2_SECRET: creds_q[1].secret <= cfg.wdata;
				kplock_pkg::REG_U3_LOGIN:  creds_q[2].login  <= cfg.wdata;
				kplock_pkg::REG_U3_SECRET: creds_q[2].secret <= cfg.wdata;
				default: begin
				end
			endcase
		end
	end

	// entry state updates on the same edge the result is captured
	kplock_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (in_req_s1),
		.creds  (creds_q),
		.rsp    (step_rsp)
	);

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_s2)
		else $error("request stepped but no result captured");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && !result.ready |-> !advance)
		else $error("pending result overwritten");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && !advance |-> !keys.ready)
		else $error("held request could be replaced");

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the keypad login and password lock: a scripted
// opening sequence followed by random login/password traffic under several
// credential settings, with every result compared against the scripted outcome or
// against a built-in model
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumCfgRegs  = 6;
	localparam int ScriptRows  = 25;
	localparam int MaxGap      = 10;
	localparam int HoldCycles  = 120;
	localparam int DrainCycles = 8;
	localparam int StallLimit  = 2000;
	localparam int ReportMax   = 10;
	localparam int PhaseReqs   = 250;

	// one row of the scripted opening: request plus, where obvious, the outcome
	typedef struct {
		kplock_pkg::op_t  op;
		kplock_pkg::key_t key;
		bit               typed;
		kplock_pkg::rsp_t want;
	} script_row_t;

	logic clk;
	logic arst_n;

	kplock_stream_if #(.payload_t(kplock_pkg::req_t)) keys_if ();
	kplock_stream_if #(.payload_t(kplock_pkg::rsp_t)) result_if ();
	kplock_cfg_if                                     cfg_if ();

	keypad_login_password_lock u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.keys   (keys_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	// lock model state, updated as each request is accepted
	kplock_pkg::code_t    user_regs [NumCfgRegs];
	kplock_pkg::phase_t   lock_phase;
	logic [kplock_pkg::CountW-1:0] entry_cnt;
	kplock_pkg::code_t    keys_entered;
	kplock_pkg::user_id_t active_user;

	kplock_pkg::rsp_t lock_outcomes_due [$];
	int   fail_count;
	int   requests_sent;
	bit   no_idle;
	bit   press_hold;
	int   idle_cycles;

	script_row_t script [ScriptRows];

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// model of one accepted request: returns the outcome the lock must give
	function automatic kplock_pkg::rsp_t advance_lock(kplock_pkg::req_t rq);
		kplock_pkg::rsp_t     rs;
		kplock_pkg::code_t    code;
		kplock_pkg::user_id_t hit;
		rs = '0;
		rs.status = kplock_pkg::ST_KEY;
		rs.key_echo = rq.key_index;
		// fire leaves the entry state untouched and blanks user and key
		if (rq.operation == kplock_pkg::OP_FIRE) begin
			rs.status = kplock_pkg::ST_FIRE;
			rs.key_echo = '0;
			rs.door_unlock = 1'b1;
			rs.alarm = 1'b1;
			return rs;
		end
		keys_entered = {keys_entered[kplock_pkg::CodeW-kplock_pkg::KeyW-1:0], rq.key_index};
		entry_cnt = entry_cnt + 1'b1;
		if (entry_cnt < kplock_pkg::KeysPerCode) begin
			rs.user_id = (lock_phase == kplock_pkg::PH_PASS) ? active_user : '0;
			return rs;
		end
		code = keys_entered;
		entry_cnt = '0;
		keys_entered = '0;
		if (lock_phase == kplock_pkg::PH_LOGIN) begin
			// every login compared, the highest matching user wins
			hit = '0;
			for (int u = 0; u < kplock_pkg::NumUsers; u++)
				if (code == user_regs[2*u])
					hit = kplock_pkg::user_id_t'(u + 1);
			if (hit == '0) begin
				rs.status = kplock_pkg::ST_LOGIN_BAD;
			end else begin
				active_user = hit;
				lock_phase = kplock_pkg::PH_PASS;
				rs.status = kplock_pkg::ST_LOGIN_OK;
				rs.user_id = hit;
			end
			return rs;
		end
		rs.user_id = active_user;
		if (active_user != '0 && code == user_regs[2*(int'(active_user) - 1) + 1]) begin
			rs.status = kplock_pkg::ST_GRANTED;
			rs.door_unlock = 1'b1;
		end else begin
			rs.status = kplock_pkg::ST_PASS_BAD;
		end
		lock_phase = kplock_pkg::PH_LOGIN;
		active_user = '0;
		return rs;
	endfunction

	function automatic string fmt_rsp(kplock_pkg::rsp_t r);
		return $sformatf("status=%0d user=%0d key=%0d unlock=%0b alarm=%0b",
			r.status, r.user_id, r.key_echo, r.door_unlock, r.alarm);
	endfunction

	function automatic script_row_t step_row(kplock_pkg::op_t op, kplock_pkg::key_t k,
			bit typed, kplock_pkg::status_t st, kplock_pkg::user_id_t uid,
			logic unlock, logic alm);
		script_row_t r;
		r.op = op;
		r.key = k;
		r.typed = typed;
		r.want = '0;
		r.want.status = st;
		r.want.user_id = uid;
		r.want.key_echo = (op == kplock_pkg::OP_FIRE) ? kplock_pkg::key_t'(0) : k;
		r.want.door_unlock = unlock;
		r.want.alarm = alm;
		return r;
	endfunction

	// offer one request after a random gap; called and returns at a falling edge
	task automatic push_request(kplock_pkg::op_t op, kplock_pkg::key_t key,
			bit typed = 1'b0, kplock_pkg::rsp_t want = '0);
		int               gap;
		kplock_pkg::req_t rq;
		kplock_pkg::rsp_t pred;
		gap = no_idle ? 0 : $urandom_range(0, MaxGap);
		rq.operation = op;
		rq.key_index = key;
		repeat (gap) begin
			keys_if.valid <= 1'b0;
			@(negedge clk);
		end
		keys_if.valid <= 1'b1;
		keys_if.data <= rq;
		do @(posedge clk); while (!keys_if.ready);
		pred = advance_lock(rq);
		lock_outcomes_due.push_back(typed ? want : pred);
		requests_sent++;
		@(negedge clk);
	endtask

	// three keys of a code, first key from the top nibble, fire now and then
	task automatic send_code(kplock_pkg::code_t c);
		for (int i = kplock_pkg::KeysPerCode - 1; i >= 0; i--) begin
			if ($urandom_range(0, 9) == 0)
				push_request(kplock_pkg::OP_FIRE, kplock_pkg::key_t'($urandom));
			push_request(kplock_pkg::OP_KEY, c[i*kplock_pkg::KeyW +: kplock_pkg::KeyW]);
		end
	endtask

	// leaves valid high so back-to-back writes need no toggle
	task automatic write_reg(logic [kplock_pkg::CfgIdxW-1:0] idx, kplock_pkg::code_t val);
		cfg_if.valid <= 1'b1;
		cfg_if.reg_index <= idx;
		cfg_if.wdata <= val;
		do @(posedge clk); while (!cfg_if.ready);
		if (idx < NumCfgRegs)
			user_regs[idx] = val;
		@(negedge clk);
	endtask

	// new credentials, only once every outcome is back and the pipe has drained
	task automatic set_credentials(kplock_pkg::code_t l1, kplock_pkg::code_t s1,
			kplock_pkg::code_t l2, kplock_pkg::code_t s2,
			kplock_pkg::code_t l3, kplock_pkg::code_t s3);
		while (lock_outcomes_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(kplock_pkg::REG_U1_LOGIN, l1);
		write_reg(kplock_pkg::REG_U1_SECRET, s1);
		write_reg(kplock_pkg::REG_U2_LOGIN, l2);
		write_reg(kplock_pkg::REG_U2_SECRET, s2);
		write_reg(kplock_pkg::REG_U3_LOGIN, l3);
		write_reg(kplock_pkg::REG_U3_SECRET, s3);
		// an index past the last register must change nothing
		write_reg(kplock_pkg::CfgIdxW'(NumCfgRegs + $urandom_range(0, 1)),
			kplock_pkg::code_t'($urandom));
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	// random traffic, mostly complete login/password sequences
	task automatic run_traffic(int n_req);
		int stop_at;
		int pick;
		int u;
		stop_at = requests_sent + n_req;
		while (requests_sent < stop_at) begin
			if ($urandom_range(0, 15) == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				// get back to the start of a login before a clean attempt
				while (entry_cnt != '0 || lock_phase != kplock_pkg::PH_LOGIN)
					push_request(kplock_pkg::OP_KEY, kplock_pkg::key_t'($urandom));
				u = $urandom_range(0, kplock_pkg::NumUsers - 1);
				send_code(user_regs[2*u]);
				if (lock_phase == kplock_pkg::PH_PASS) begin
					if ($urandom_range(0, 9) < 7)
						send_code(user_regs[2*(int'(active_user) - 1) + 1]);
					else
						send_code(kplock_pkg::code_t'($urandom));
				end
			end else if (pick < 85) begin
				push_request(kplock_pkg::OP_KEY, kplock_pkg::key_t'($urandom));
			end else if (pick < 95) begin
				push_request(kplock_pkg::OP_FIRE, kplock_pkg::key_t'($urandom));
			end else begin
				// broken attempt: first login key right, then junk
				u = $urandom_range(0, kplock_pkg::NumUsers - 1);
				push_request(kplock_pkg::OP_KEY,
					user_regs[2*u][kplock_pkg::CodeW-1 -: kplock_pkg::KeyW]);
				push_request(kplock_pkg::OP_KEY, kplock_pkg::key_t'($urandom));
			end
		end
		keys_if.valid <= 1'b0;
	endtask

	// result side: random stall per result, one long hold on request
	initial begin : result_sink
		int               stall;
		kplock_pkg::rsp_t got;
		kplock_pkg::rsp_t want;
		result_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (press_hold) begin
				// long hold so the lock backs up and stalls the key channel
				result_if.ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				press_hold = 1'b0;
			end
			stall = no_idle ? 0 : $urandom_range(0, MaxGap);
			if (stall != 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!(result_if.valid && result_if.ready));
			got = result_if.data;
			if (lock_outcomes_due.size() == 0) begin
				fail_count++;
				if (fail_count <= ReportMax)
					$display("unexpected result: %s", fmt_rsp(got));
			end else begin
				want = lock_outcomes_due.pop_front();
				if (got.status !== want.status || got.user_id !== want.user_id ||
						got.key_echo !== want.key_echo ||
						got.door_unlock !== want.door_unlock || got.alarm !== want.alarm) begin
					fail_count++;
					if (fail_count <= ReportMax)
						$display("mismatch at %0t: expected %s, got %s", $realtime,
							fmt_rsp(want), fmt_rsp(got));
				end
			end
			@(negedge clk);
		end
	end

	// watchdog: too long without any handshake ends the run
	initial begin : watchdog
		idle_cycles = 0;
		while (idle_cycles < StallLimit) begin
			@(posedge clk);
			if ((keys_if.valid && keys_if.ready) || (result_if.valid && result_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no handshake for %0d cycles", StallLimit);
		$display("** keypad_login_password_lock: FAILED **");
		$finish;
	end

	initial begin : stimulus
		// every input known from time zero
		arst_n = 1'b0;
		keys_if.valid = 1'b0;
		keys_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.reg_index = '0;
		cfg_if.wdata = '0;
		fail_count = 0;
		requests_sent = 0;
		no_idle = 1'b0;
		press_hold = 1'b0;

		// model starts from the reset credentials
		user_regs[kplock_pkg::REG_U1_LOGIN] = kplock_pkg::U1LoginRst;
		user_regs[kplock_pkg::REG_U1_SECRET] = kplock_pkg::U1SecretRst;
		user_regs[kplock_pkg::REG_U2_LOGIN] = kplock_pkg::U2LoginRst;
		user_regs[kplock_pkg::REG_U2_SECRET] = kplock_pkg::U2SecretRst;
		user_regs[kplock_pkg::REG_U3_LOGIN] = kplock_pkg::U3LoginRst;
		user_regs[kplock_pkg::REG_U3_SECRET] = kplock_pkg::U3SecretRst;
		lock_phase = kplock_pkg::PH_LOGIN;
		entry_cnt = '0;
		keys_entered = '0;
		active_user = '0;

		// opening script on reset credentials:
		// user one 3-7-B / 0-1-2, user two 7-B-F / 1-2-4, user three B-F-C / 2-4-5
		script = '{
			// user one logs in, a fire event lands mid login and must not disturb it
			step_row(kplock_pkg::OP_KEY,  4'h3, 1'b1, kplock_pkg::ST_KEY,       2'd0, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'h7, 1'b0, kplock_pkg::ST_KEY,       2'd0, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_FIRE, 4'hF, 1'b1, kplock_pkg::ST_FIRE,      2'd0, 1'b1, 1'b1),
			step_row(kplock_pkg::OP_KEY,  4'hB, 1'b1, kplock_pkg::ST_LOGIN_OK,  2'd1, 1'b0, 1'b0),
			// right password opens the door, key zero at the low extreme
			step_row(kplock_pkg::OP_KEY,  4'h0, 1'b1, kplock_pkg::ST_KEY,       2'd1, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'h1, 1'b0, kplock_pkg::ST_KEY,       2'd1, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'h2, 1'b1, kplock_pkg::ST_GRANTED,   2'd1, 1'b1, 1'b0),
			// all-ones and all-zeros logins match nobody
			step_row(kplock_pkg::OP_KEY,  4'hF, 1'b1, kplock_pkg::ST_KEY,       2'd0, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'hF, 1'b0, kplock_pkg::ST_KEY,       2'd0, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'hF, 1'b1, kplock_pkg::ST_LOGIN_BAD, 2'd0, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'h0, 1'b0, kplock_pkg::ST_KEY,       2'd0, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'h0, 1'b0, kplock_pkg::ST_KEY,       2'd0, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'h0, 1'b1, kplock_pkg::ST_LOGIN_BAD, 2'd0, 1'b0, 1'b0),
			// user two with a wrong password
			step_row(kplock_pkg::OP_KEY,  4'h7, 1'b0, kplock_pkg::ST_KEY,       2'd0, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'hB, 1'b0, kplock_pkg::ST_KEY,       2'd0, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'hF, 1'b1, kplock_pkg::ST_LOGIN_OK,  2'd2, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'h1, 1'b0, kplock_pkg::ST_KEY,       2'd2, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'h2, 1'b0, kplock_pkg::ST_KEY,       2'd2, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'h3, 1'b1, kplock_pkg::ST_PASS_BAD,  2'd2, 1'b0, 1'b0),
			// user three granted
			step_row(kplock_pkg::OP_KEY,  4'hB, 1'b0, kplock_pkg::ST_KEY,       2'd0, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'hF, 1'b0, kplock_pkg::ST_KEY,       2'd0, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'hC, 1'b1, kplock_pkg::ST_LOGIN_OK,  2'd3, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'h2, 1'b0, kplock_pkg::ST_KEY,       2'd3, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'h4, 1'b0, kplock_pkg::ST_KEY,       2'd3, 1'b0, 1'b0),
			step_row(kplock_pkg::OP_KEY,  4'h5, 1'b1, kplock_pkg::ST_GRANTED,   2'd3, 1'b1, 1'b0)
		};

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < ScriptRows; i++)
			push_request(script[i].op, script[i].key, script[i].typed, script[i].want);
		keys_if.valid <= 1'b0;

		// all credentials zero: every login matches, user three must win
		set_credentials('0, '0, '0, '0, '0, '0);
		run_traffic(PhaseReqs);

		// all credentials at the top of their range
		set_credentials('1, '1, '1, '1, '1, '1);
		run_traffic(PhaseReqs);

		// users one and two share a login, user three differs
		begin : shared_login
			kplock_pkg::code_t shared;
			shared = kplock_pkg::code_t'($urandom);
			set_credentials(shared, kplock_pkg::code_t'($urandom), shared,
				kplock_pkg::code_t'($urandom), kplock_pkg::code_t'($urandom),
				kplock_pkg::code_t'($urandom));
		end
		run_traffic(PhaseReqs);

		// random credentials, with a long hold on the result side
		set_credentials(kplock_pkg::code_t'($urandom), kplock_pkg::code_t'($urandom),
			kplock_pkg::code_t'($urandom), kplock_pkg::code_t'($urandom),
			kplock_pkg::code_t'($urandom), kplock_pkg::code_t'($urandom));
		no_idle = 1'b1;
		press_hold = 1'b1;
		run_traffic(PhaseReqs);

		// back to the reset values, written explicitly
		set_credentials(kplock_pkg::U1LoginRst, kplock_pkg::U1SecretRst,
			kplock_pkg::U2LoginRst, kplock_pkg::U2SecretRst,
			kplock_pkg::U3LoginRst, kplock_pkg::U3SecretRst);
		run_traffic(PhaseReqs);

		set_credentials(kplock_pkg::code_t'($urandom), kplock_pkg::code_t'($urandom),
			kplock_pkg::code_t'($urandom), kplock_pkg::code_t'($urandom),
			kplock_pkg::code_t'($urandom), kplock_pkg::code_t'($urandom));
		run_traffic(PhaseReqs);

		// drain, then keep watching for stray results
		while (lock_outcomes_due.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (lock_outcomes_due.size() != 0) begin
			fail_count += lock_outcomes_due.size();
			$display("%0d expected results never arrived", lock_outcomes_due.size());
		end

		if (fail_count == 0)
			$display("** keypad_login_password_lock: PASSED **");
		else
			$display("** keypad_login_password_lock: FAILED **");
		$finish;
	end

endmodule
